>>> sv/cstrip_pkg.sv
// ----------------------------------------------------------------------------
// cstrip_pkg
// Shared types and character constants for the C comment stripper.
// ----------------------------------------------------------------------------
package cstrip_pkg;

  // Characters of interest
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChNl     = 8'h0A;

  // Most result words one input byte can release
  localparam int unsigned MaxRes  = 3;
  // Output queue depth: one word in flight plus a full burst
  localparam int unsigned QDepth  = 4;

  // One result word
  typedef struct packed {
    logic [7:0] chr;
    logic       has;
    logic       last;
  } res_t;

  // Result words released by one input byte, slot 0 first
  typedef struct packed {
    logic [1:0]            cnt;
    res_t [MaxRes-1:0]     item;
  } res_grp_t;

endpackage

>>> sv/cstrip_core.sv
// ----------------------------------------------------------------------------
// cstrip_core
// Comment and string tracking, two-byte hold buffer and release of words.
// ----------------------------------------------------------------------------
module cstrip_core
  import cstrip_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       accept_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output res_grp_t   grp_o
);

  logic       strip_q;
  logic       str_q, str_d;
  logic       lc_q, lc_d;
  logic       bc_q, bc_d;
  logic [7:0] prev_q, prev_d;
  logic [7:0] h0_q, h0_d;
  logic [7:0] h1_q, h1_d;
  logic [1:0] hc_q, hc_d;
  res_grp_t   grp;

  // Next state and released words for the byte on the input
  always_comb begin
    logic       in_cmt;
    logic       do_wd;
    logic [7:0] wd_exp;
    logic [7:0] newest;
    logic [1:0] n;
    res_t [MaxRes-1:0] rs;

    str_d  = str_q;
    lc_d   = lc_q;
    bc_d   = bc_q;
    prev_d = char_i;
    h0_d   = h0_q;
    h1_d   = h1_q;
    hc_d   = hc_q;
    n      = 2'd0;
    rs     = '0;
    do_wd  = 1'b0;
    wd_exp = ChSlash;
    newest = h0_q;
    in_cmt = lc_q | bc_q;

    if (!strip_q) begin
      // pass-through: drain held bytes, then the input byte
      if (hc_q != 2'd0) begin
        rs[n] = '{chr: h0_q, has: 1'b1, last: 1'b0};
        n = n + 2'd1;
      end
      if (hc_q == 2'd2) begin
        rs[n] = '{chr: h1_q, has: 1'b1, last: 1'b0};
        n = n + 2'd1;
      end
      hc_d = 2'd0;
      rs[n] = '{chr: char_i, has: 1'b1, last: 1'b0};
      n = n + 2'd1;
    end else begin
      // mode tracking
      if (!in_cmt && char_i == ChQuote && prev_q != ChBslash) begin
        str_d = ~str_q;
      end else if (str_q) begin
        // string body, nothing to track
      end else if (!in_cmt && char_i == ChSlash && prev_q == ChSlash) begin
        lc_d   = 1'b1;
        do_wd  = 1'b1;
        prev_d = 8'h00;
      end else if (!in_cmt && char_i == ChStar && prev_q == ChSlash) begin
        bc_d   = 1'b1;
        do_wd  = 1'b1;
        prev_d = 8'h00;
      end else if (char_i == ChNl && prev_q != ChBslash) begin
        lc_d = 1'b0;
      end

      // hold, splice or close
      if (!lc_d && !bc_d) begin
        if (char_i == ChNl && prev_q == ChBslash) begin
          do_wd  = 1'b1;
          wd_exp = ChBslash;
        end else begin
          if (hc_d == 2'd2) begin
            rs[n] = '{chr: h0_q, has: 1'b1, last: 1'b0};
            n = n + 2'd1;
            h0_d = h1_q;
            h1_d = char_i;
          end else if (hc_d == 2'd1) begin
            h1_d = char_i;
            hc_d = 2'd2;
          end else begin
            h0_d = char_i;
            hc_d = 2'd1;
          end
        end
      end else if (bc_d && in_cmt && char_i == ChSlash && prev_q == ChStar) begin
        bc_d   = 1'b0;
        prev_d = 8'h00;
      end

      // withdraw newest held byte if it is the expected one
      newest = (hc_q == 2'd2) ? h1_q : h0_q;
      if (do_wd && hc_q != 2'd0 && newest == wd_exp) begin
        hc_d = hc_q - 2'd1;
      end
    end

    // end of stream: flush and mark the final word
    if (last_i) begin
      if (hc_d != 2'd0) begin
        rs[n] = '{chr: h0_d, has: 1'b1, last: (hc_d == 2'd1)};
        n = n + 2'd1;
        if (hc_d == 2'd2) begin
          rs[n] = '{chr: h1_d, has: 1'b1, last: 1'b1};
          n = n + 2'd1;
        end
      end else if (n != 2'd0) begin
        rs[n - 2'd1].last = 1'b1;
      end else begin
        rs[n] = '{chr: 8'h00, has: 1'b0, last: 1'b1};
        n = n + 2'd1;
      end
      str_d  = 1'b0;
      lc_d   = 1'b0;
      bc_d   = 1'b0;
      prev_d = 8'h00;
      hc_d   = 2'd0;
    end

    grp.cnt  = n;
    grp.item = rs;
  end

  assign grp_o = grp;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 1'b1;
      str_q   <= 1'b0;
      lc_q    <= 1'b0;
      bc_q    <= 1'b0;
      prev_q  <= 8'h00;
      hc_q    <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        strip_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        str_q  <= str_d;
        lc_q   <= lc_d;
        bc_q   <= bc_d;
        prev_q <= prev_d;
        hc_q   <= hc_d;
      end
    end
  end

  // Held bytes, only read below the fill count
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      h0_q <= h0_d;
      h1_q <= h1_d;
    end
  end

  // Checks
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_i) |=> (hc_q == 2'd0 && !lc_q && !bc_q && !str_q))
    else $error("stream state not cleared after final byte");

  a_hold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q != 2'd3)
    else $error("hold count out of range");

  a_last_yields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_i || !strip_q) |-> grp.cnt != 2'd0)
    else $error("final or pass-through byte released nothing");

endmodule

>>> sv/cstrip_outq.sv
// ----------------------------------------------------------------------------
// cstrip_outq
// Shift-register result queue: takes a burst of up to three words per cycle
// while room is open; presents the oldest word at a fixed head register.
// ----------------------------------------------------------------------------
module cstrip_outq
  import cstrip_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  res_grp_t grp_i,
  output logic     room_o,
  output logic     valid_o,
  input  logic     ready_i,
  output res_t     head_o
);

  localparam int unsigned CntW = $clog2(QDepth + 1);

  res_t [QDepth-1:0] q_q, q_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;
  logic [CntW-1:0]   push_n;

  assign pop    = valid_o && ready_i;
  assign push_n = push_i ? CntW'(grp_i.cnt) : '0;

  // Shift out the head, then append the new words behind what remains
  always_comb begin
    res_t [QDepth-1:0] sh;
    logic [CntW-1:0]   base;
    logic [CntW-1:0]   k;

    base = cnt_q - CntW'(pop);
    for (int i = 0; i < QDepth - 1; i++) begin
      sh[i] = pop ? q_q[i+1] : q_q[i];
    end
    sh[QDepth-1] = q_q[QDepth-1];

    q_d = sh;
    for (int i = 0; i < QDepth; i++) begin
      k = CntW'(i) - base;
      if (CntW'(i) >= base && k < push_n) begin
        q_d[i] = grp_i.item[k[1:0]];
      end
    end
    cnt_d = base + push_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign valid_o = cnt_q != '0;
  assign head_o  = q_q[0];
  assign room_o  = cnt_q <= CntW'(QDepth - MaxRes);

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("burst pushed without room");

endmodule

>>> sv/c_comment_stripper_unit.sv
// ----------------------------------------------------------------------------
// c_comment_stripper_unit
// A released word is registered in the result queue behind any older words.
// Throughput: one byte per cycle while the sink is ready and each byte releases
//   at most one word; a byte releasing two or three words stalls the input.
// Input readiness is set by the four-entry result queue (room for a burst).
// Reset (async, active low) clears all flags and counts; stripping is enabled.
// ----------------------------------------------------------------------------
module c_comment_stripper_unit
  import cstrip_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: strip_enable
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // source bytes
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic       s_axis_tlast,   // in_last
  // released words
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tuser,   // [0] has_char
  output logic       m_axis_tlast    // out_last
);

  logic     room;
  logic     accept;
  res_grp_t grp;
  res_t     head;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  // Tracking and hold buffer
  cstrip_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .char_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .grp_o       (grp)
  );

  // Result queue
  cstrip_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .grp_i   (grp),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = head.chr;
  assign m_axis_tuser = head.has;
  assign m_axis_tlast = head.last;

  // Checks
  a_last_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> m_axis_tvalid)
    else $error("no result word after final byte");

endmodule

>>> dv/c_comment_stripper_unit_test.sv
// ----------------------------------------------------------------------------
// c_comment_stripper_unit_test
// Self-checking bench for the C comment stripper. A byte queue feeds a
// streaming driver; every accepted byte runs through an in-bench model of the
// stripper, and the words it releases are compared field by field, in order,
// with what comes out of the master side. Phases switch stripping on and off
// and vary source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module c_comment_stripper_unit_test
  import cstrip_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ChLowA    = 8'h61;
  localparam int         WdogLimit = 2000;

  // One source byte with its end-of-stream flag
  typedef struct {
    logic [7:0] chr;
    logic       last;
  } src_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_wdata_i   = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  src_t src_bytes[$];
  res_t exp_words[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_fail         = 0;
  int n_words        = 0;
  int idle_cycles    = 0;

  // Model state
  logic       cfg_strip = 1'b1;
  logic       in_str, in_line, in_blk;
  logic [7:0] prev_chr;
  logic [7:0] held [2];
  int         held_n;

  c_comment_stripper_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model --

  task automatic clear_stream();
    in_str   = 1'b0;
    in_line  = 1'b0;
    in_blk   = 1'b0;
    prev_chr = 8'h00;
    held[0]  = 8'h00;
    held[1]  = 8'h00;
    held_n   = 0;
  endtask

  task automatic push_word(input logic [7:0] c, input logic has, input logic lst);
    res_t w;
    w.chr  = c;
    w.has  = has;
    w.last = lst;
    exp_words.push_back(w);
  endtask

  // Buffer a byte; a third byte pushes the oldest one out
  task automatic keep_byte(input logic [7:0] c);
    if (held_n >= 2) begin
      push_word(held[0], 1'b1, 1'b0);
      held[0] = held[1];
      held_n  = 1;
    end
    held[held_n] = c;
    held_n++;
  endtask

  // Take back the newest held byte, only if it is the one expected
  task automatic take_back(input logic [7:0] c);
    if (held_n > 0 && held[held_n-1] == c) held_n--;
  endtask

  task automatic strip_byte(input logic [7:0] c, input logic lst);
    logic [7:0] prv;
    logic [7:0] nprv;
    logic       was_cmt;
    int         n0;
    n0 = exp_words.size();
    if (!cfg_strip) begin
      for (int i = 0; i < held_n; i++) push_word(held[i], 1'b1, 1'b0);
      held_n = 0;
      push_word(c, 1'b1, 1'b0);
      prev_chr = c;
    end else begin
      prv     = prev_chr;
      nprv    = c;
      was_cmt = in_line || in_blk;
      if (!was_cmt && c == ChQuote && prv != ChBslash) begin
        in_str = ~in_str;
      end else if (in_str) begin
        // string text passes untouched
      end else if (!was_cmt && c == ChSlash && prv == ChSlash) begin
        in_line = 1'b1;
        take_back(ChSlash);
        nprv = 8'h00;
      end else if (!was_cmt && c == ChStar && prv == ChSlash) begin
        in_blk = 1'b1;
        take_back(ChSlash);
        nprv = 8'h00;
      end else if (c == ChNl && prv != ChBslash) begin
        in_line = 1'b0;
      end
      if (!in_line && !in_blk) begin
        if (c == ChNl && prv == ChBslash) take_back(ChBslash);
        else keep_byte(c);
      end else if (in_blk && was_cmt && c == ChSlash && prv == ChStar) begin
        in_blk = 1'b0;
        nprv   = 8'h00;
      end
      prev_chr = nprv;
    end
    // end of stream: flush, mark the final word, or send a bare marker
    if (lst) begin
      if (held_n > 0) begin
        for (int i = 0; i < held_n; i++) push_word(held[i], 1'b1, (i + 1 == held_n));
      end else if (exp_words.size() > n0) begin
        exp_words[exp_words.size()-1].last = 1'b1;
      end else begin
        push_word(8'h00, 1'b0, 1'b1);
      end
      clear_stream();
    end
  endtask

  // ------------------------------------------------------------- stimulus --

  task automatic add_src(input logic [7:0] c, input logic lst = 1'b0);
    src_t s;
    s.chr  = c;
    s.last = lst;
    src_bytes.push_back(s);
  endtask

  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 9))
      0:       return ChSlash;
      1:       return ChStar;
      2:       return ChQuote;
      3:       return ChBslash;
      4:       return ChNl;
      default: return ChLowA + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // Wait until every byte is in and every word is out, then let it settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (src_bytes.size() != 0 || s_axis_tvalid || exp_words.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic en, input int send_pct, input int stall_pct,
                           input int n_items);
    int n0;
    int len;
    int kind;
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    cfg_strip    = en;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    // mostly C-shaped snippets with random text, some noise and broken pieces
    while (n_items > 0) begin
      n0   = src_bytes.size();
      kind = $urandom_range(0, 99);
      len  = $urandom_range(0, 6);
      if (kind < 15) begin
        add_src(ChSlash);
        add_src(ChSlash);
        repeat (len) add_src(text_byte());
        add_src(ChNl);
      end else if (kind < 35) begin
        add_src(ChSlash);
        add_src(ChStar);
        repeat (len) add_src(text_byte());
        if ($urandom_range(0, 3) == 0) add_src(ChStar);
        add_src(ChStar);
        add_src(ChSlash);
      end else if (kind < 50) begin
        add_src(ChQuote);
        repeat (len) begin
          if ($urandom_range(0, 4) == 0) add_src(ChBslash);
          add_src(text_byte());
        end
        add_src(ChQuote);
      end else if (kind < 58) begin
        add_src(ChBslash);
        add_src(ChNl);
      end else if (kind < 72) begin
        repeat (len + 1) add_src(ChLowA + 8'($urandom_range(0, 25)));
      end else if (kind < 84) begin
        repeat (len + 1) add_src(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 3))
          0: add_src(ChSlash);
          1: begin add_src(ChStar); add_src(ChSlash); end
          2: begin add_src(ChSlash); add_src(ChNl); end
          default: begin add_src(ChBslash); add_src(ChQuote); end
        endcase
      end
      if ($urandom_range(0, 7) == 0) src_bytes[src_bytes.size()-1].last = 1'b1;
      n_items -= src_bytes.size() - n0;
    end
  endtask

  // --------------------------------------------------------------- driver --

  always @(posedge clk_i) begin
    src_t s;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) strip_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s = src_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= s.chr;
          s_axis_tlast  <= s.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------- monitor --

  task automatic report_mismatch(input string what, input int got, input int want);
    n_fail++;
    $display("word %0d: %s got %0h want %0h", n_words, what, got, want);
  endtask

  always @(posedge clk_i) begin
    res_t w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_words.size() == 0) begin
          report_mismatch("word with none expected, tdata", m_axis_tdata, 0);
        end else begin
          w = exp_words.pop_front();
          if (m_axis_tdata !== w.chr)  report_mismatch("out_char", m_axis_tdata, w.chr);
          if (m_axis_tuser !== w.has)  report_mismatch("has_char", m_axis_tuser, w.has);
          if (m_axis_tlast !== w.last) report_mismatch("out_last", m_axis_tlast, w.last);
        end
        n_words++;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WdogLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ----------------------------------------------------------------- main --

  initial begin
    clear_stream();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: stripping on, no idling
    run_phase(1'b1, 0, 0, 0);
    // lone byte flushed as the final word
    add_src(ChLowA, 1'b1);
    // line comment swallowing everything: bare end marker
    add_src(ChSlash);
    add_src(ChSlash);
    add_src(ChLowA + 8'd23, 1'b1);
    // opener's star does not close; a later closer does
    add_src(ChSlash);
    add_src(ChStar);
    add_src(ChSlash);
    add_src(ChStar);
    add_src(ChSlash);
    add_src(ChLowA + 8'd1, 1'b1);
    // comment opener inside a string
    add_src(ChQuote);
    add_src(ChSlash);
    add_src(ChSlash);
    add_src(ChQuote, 1'b1);
    // line splice on its own
    add_src(ChBslash);
    add_src(ChNl, 1'b1);
    // escaped quote does not toggle string mode
    add_src(ChBslash);
    add_src(ChQuote);
    add_src(ChLowA + 8'd16, 1'b1);
    // byte extremes
    add_src(8'h00);
    add_src(8'hFF, 1'b1);
    // closer outside a comment, then a line comment ended by a newline
    add_src(ChStar);
    add_src(ChSlash);
    add_src(ChSlash);
    add_src(ChNl, 1'b1);

    // Random phases across both settings and all idling patterns
    run_phase(1'b1, 0, 0, 60);
    run_phase(1'b0, 55, 0, 50);
    run_phase(1'b1, 0, 55, 60);
    run_phase(1'b1, 13, 13, 60);
    run_phase(1'b0, 0, 0, 40);
    run_phase(1'b1, 55, 55, 60);

    wait_idle();
    repeat (12) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/cstrip_pkg.sv
sv/cstrip_core.sv
sv/cstrip_outq.sv
sv/c_comment_stripper_unit.sv
dv/c_comment_stripper_unit_test.sv
